// ===== design/fan_pwm_tach_controller_core_macros.svh =====
// Assertion macros shared by the fan controller core.
`ifndef FAN_PWM_TACH_CONTROLLER_CORE_MACROS_SVH
`define FAN_PWM_TACH_CONTROLLER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define FPTC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fptc assertion failed");
// Next-cycle implication.
`define FPTC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fptc assertion failed");
`else
`define FPTC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FPTC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/fptc_pkg.sv =====
// Types and constants for the fan PWM and tachometer controller.
`timescale 1ns / 1ps
package fptc_pkg;

   localparam int OP_W       = 2;
   localparam int PCT_W      = 8;
   localparam int SPEED_W    = 7;
   localparam int DUTY_W     = 16;
   localparam int RPM_W      = 16;
   localparam int TOTAL_W    = 32;
   localparam int RES_W      = 5;
   localparam int PPR_W      = 8;
   localparam int IVL_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Divider: 16 quotient bits, divisor up to ppr * interval.
   localparam int QUO_W  = 16;
   localparam int DEN_W  = PPR_W + IVL_W;
   localparam int STEP_W = $clog2(QUO_W);
   localparam int DUTY_PROD_W = SPEED_W + DUTY_W;

   localparam logic [15:0]        RPM_SCALE   = 16'd60000;
   localparam logic [SPEED_W-1:0] SPEED_MAX   = 7'd100;
   localparam logic [DEN_W-1:0]   DUTY_DIV    = 24'd100;
   localparam logic [RES_W-1:0]   RES_MAX     = 5'd16;
   localparam logic [RPM_W-1:0]   RPM_SAT     = 16'hFFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_PWM_RES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PPR     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IVL     = 2'd2;

   typedef enum logic [OP_W-1:0] {
      OP_TICK      = 2'd0,
      OP_TACH      = 2'd1,
      OP_SET_SPEED = 2'd2,
      OP_NONE      = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_RPM_MUL,
      S_RPM_CHK,
      S_DUTY_MUL,
      S_DUTY_INIT,
      S_DIV_RPM,
      S_DIV_DUTY,
      S_RPM_WB,
      S_DUTY_WB,
      S_RESP
   } state_type;

   typedef struct packed {
      logic load_item;
      logic tick_count;
      logic tick_update;
      logic tach;
      logic set_speed;
      logic rpm_mul;
      logic rpm_sat;
      logic duty_mul;
      logic div_init;
      logic div_step;
      logic rpm_wb;
      logic duty_wb;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   tick_due;
      logic   rpm_over;
   } status_type;

endpackage

// ===== design/fan_pwm_tach_controller_core.sv =====
// Top level of the fan PWM duty and tachometer rpm controller.
//
//   port group  direction  handshake            carries
//   req_        in         req_valid/req_stall  op, speed_percent
//   rsp_        out        rsp_valid/rsp_stall  duty, fan_on, speed_now, rpm, pulse_total
//   csr_        in         csr_we               csr_index, csr_wdata
//
// One event at a time. A tick without update, a tach edge or an idle op goes from decode
// straight to the response; a set-speed or an rpm update runs through the 16-step restoring divider
// shared by the rpm and duty paths. A saturated rpm skips the divider.
// Reset is synchronous and restores the register defaults and clears all counters.
// The result sits in an output register, so a stalled rsp_ does not block the next req_.
`timescale 1ns / 1ps
module fan_pwm_tach_controller_core #(
   parameter int PULSE_COUNT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_speed_percent,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_duty,
   output logic        rsp_fan_on,
   output logic [6:0]  rsp_speed_now,
   output logic [15:0] rsp_rpm,
   output logic [31:0] rsp_pulse_total,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import fptc_pkg::*;

   cmd_type    cmd;
   status_type status;

   fptc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fptc_dp #(
      .PULSE_COUNT_BITS (PULSE_COUNT_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_op            (req_op),
      .req_speed_percent (req_speed_percent),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .status            (status),
      .rsp_duty          (rsp_duty),
      .rsp_fan_on        (rsp_fan_on),
      .rsp_speed_now     (rsp_speed_now),
      .rsp_rpm           (rsp_rpm),
      .rsp_pulse_total   (rsp_pulse_total)
   );

endmodule

// ===== design/fptc_dp.sv =====
// Datapath: event state, config registers, multipliers and shared divider.
`timescale 1ns / 1ps
module fptc_dp #(
   parameter int PULSE_COUNT_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [fptc_pkg::OP_W-1:0]           req_op,
   input  logic [fptc_pkg::PCT_W-1:0]          req_speed_percent,
   input  logic                                csr_we,
   input  logic [fptc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fptc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  fptc_pkg::cmd_type                   cmd,
   output fptc_pkg::status_type                status,
   output logic [fptc_pkg::DUTY_W-1:0]         rsp_duty,
   output logic                                rsp_fan_on,
   output logic [fptc_pkg::SPEED_W-1:0]        rsp_speed_now,
   output logic [fptc_pkg::RPM_W-1:0]          rsp_rpm,
   output logic [fptc_pkg::TOTAL_W-1:0]        rsp_pulse_total
);
   import fptc_pkg::*;

   localparam int NUM_W = PULSE_COUNT_BITS + 16;
   localparam int CMP_W = (NUM_W > DEN_W + 16) ? NUM_W : DEN_W + 16;

   logic [RES_W-1:0] res_ff, res_in;
   logic [PPR_W-1:0] ppr_ff, ppr_in;
   logic [IVL_W-1:0] ivl_ff, ivl_in;

   logic [PULSE_COUNT_BITS-1:0] pulse_ff, pulse_in;
   logic [PULSE_COUNT_BITS-1:0] last_ff, last_in;
   logic [IVL_W-1:0]   ms_ff, ms_in;
   logic [RPM_W-1:0]   rpm_ff, rpm_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic               on_ff, on_in;
   logic [DUTY_W-1:0]  duty_ff, duty_in;

   op_type             op_ff, op_in;
   logic [PCT_W-1:0]   pct_ff, pct_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;

   logic [DUTY_W-1:0]  rsp_duty_ff, rsp_duty_in;
   logic               rsp_on_ff, rsp_on_in;
   logic [SPEED_W-1:0] rsp_speed_ff, rsp_speed_in;
   logic [RPM_W-1:0]   rsp_rpm_ff, rsp_rpm_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   logic [PPR_W-1:0]   ppr_eff;
   logic [IVL_W-1:0]   ivl_eff;
   logic [RES_W-1:0]   res_eff;
   logic [IVL_W-1:0]   ms_next;
   logic [16:0]        one_sh;
   logic [DUTY_W-1:0]  max_duty;
   logic [SPEED_W-1:0] pct_cap;
   logic [DEN_W:0]     trial;
   logic [DEN_W:0]     trial_diff;
   logic [PULSE_COUNT_BITS-1:0] pulse_diff;

   assign ppr_eff  = (ppr_ff == '0) ? PPR_W'(1) : ppr_ff;
   assign ivl_eff  = (ivl_ff == '0) ? IVL_W'(1) : ivl_ff;
   assign res_eff  = (res_ff > RES_MAX) ? RES_MAX : res_ff;
   assign ms_next  = ms_ff + IVL_W'(1);
   assign one_sh   = 17'd1 << res_eff;
   assign max_duty = DUTY_W'(one_sh - 17'd1);
   assign pct_cap  = (pct_ff > PCT_W'(SPEED_MAX)) ? SPEED_MAX : pct_ff[SPEED_W-1:0];
   // wrap the pulse difference at the counter width before widening
   assign pulse_diff = pulse_ff - last_ff;

   // one restoring step: bring down the next dividend bit, try the subtract
   assign trial      = {rem_ff, num_ff[QUO_W-1]};
   assign trial_diff = trial - {1'b0, den_ff};

   assign status.op       = op_ff;
   assign status.tick_due = (ms_next >= ivl_eff);
   assign status.rpm_over = (CMP_W'(num_ff) >= (CMP_W'(den_ff) << 16));

   always_comb begin
      res_in = res_ff;
      ppr_in = ppr_ff;
      ivl_in = ivl_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PWM_RES: res_in = csr_wdata[RES_W-1:0];
            CSR_PPR:     ppr_in = csr_wdata[PPR_W-1:0];
            CSR_IVL:     ivl_in = csr_wdata[IVL_W-1:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      pulse_in = pulse_ff;
      last_in  = last_ff;
      ms_in    = ms_ff;
      rpm_in   = rpm_ff;
      speed_in = speed_ff;
      on_in    = on_ff;
      duty_in  = duty_ff;
      op_in    = op_ff;
      pct_in   = pct_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (cmd.load_item) begin
         op_in  = op_type'(req_op);
         pct_in = req_speed_percent;
      end
      if (cmd.tick_count) begin
         ms_in = ms_next;
      end
      if (cmd.tick_update) begin
         ms_in   = '0;
         num_in  = NUM_W'(pulse_diff);
         last_in = pulse_ff;
      end
      if (cmd.tach) begin
         pulse_in = pulse_ff + PULSE_COUNT_BITS'(1);
      end
      if (cmd.set_speed) begin
         speed_in = pct_cap;
         on_in    = (pct_cap != '0);
      end
      if (cmd.rpm_mul) begin
         num_in = NUM_W'(num_ff[PULSE_COUNT_BITS-1:0]) * NUM_W'(RPM_SCALE);
         den_in = DEN_W'(ppr_eff) * DEN_W'(ivl_eff);
      end
      if (cmd.rpm_sat) begin
         rpm_in = RPM_SAT;
      end
      if (cmd.duty_mul) begin
         num_in = NUM_W'(DUTY_PROD_W'(speed_ff) * DUTY_PROD_W'(max_duty));
         den_in = DUTY_DIV;
      end
      if (cmd.div_init) begin
         // top bits are below the divisor, so the quotient fits QUO_W bits
         rem_in = DEN_W'(num_ff >> QUO_W);
         quo_in = '0;
      end
      if (cmd.div_step) begin
         if (!trial_diff[DEN_W]) begin
            rem_in = trial_diff[DEN_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         num_in = {num_ff[NUM_W-1:QUO_W], num_ff[QUO_W-2:0], 1'b0};
      end
      if (cmd.rpm_wb) begin
         rpm_in = quo_ff;
      end
      if (cmd.duty_wb) begin
         duty_in = quo_ff;
      end
   end

   always_comb begin
      rsp_duty_in  = rsp_duty_ff;
      rsp_on_in    = rsp_on_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_rpm_in   = rsp_rpm_ff;
      rsp_total_in = rsp_total_ff;
      if (cmd.load_rsp) begin
         rsp_duty_in  = duty_ff;
         rsp_on_in    = on_ff;
         rsp_speed_in = speed_ff;
         rsp_rpm_in   = rpm_ff;
         rsp_total_in = TOTAL_W'(pulse_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff   <= RES_W'(8);
         ppr_ff   <= PPR_W'(2);
         ivl_ff   <= IVL_W'(1000);
         pulse_ff <= '0;
         last_ff  <= '0;
         ms_ff    <= '0;
         rpm_ff   <= '0;
         speed_ff <= '0;
         on_ff    <= 1'b0;
         duty_ff  <= '0;
      end else begin
         res_ff   <= res_in;
         ppr_ff   <= ppr_in;
         ivl_ff   <= ivl_in;
         pulse_ff <= pulse_in;
         last_ff  <= last_in;
         ms_ff    <= ms_in;
         rpm_ff   <= rpm_in;
         speed_ff <= speed_in;
         on_ff    <= on_in;
         duty_ff  <= duty_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pct_ff       <= pct_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      rsp_duty_ff  <= rsp_duty_in;
      rsp_on_ff    <= rsp_on_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_rpm_ff   <= rsp_rpm_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_duty        = rsp_duty_ff;
   assign rsp_fan_on      = rsp_on_ff;
   assign rsp_speed_now   = rsp_speed_ff;
   assign rsp_rpm         = rsp_rpm_ff;
   assign rsp_pulse_total = rsp_total_ff;

endmodule

// ===== design/fptc_ctrl.sv =====
// Controller: sequences each event through the datapath and owns the handshakes.
`timescale 1ns / 1ps
`include "fan_pwm_tach_controller_core_macros.svh"
module fptc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  fptc_pkg::status_type  status,
   output fptc_pkg::cmd_type     cmd
);
   import fptc_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              last_step;
   logic              rsp_free;

   assign last_step = (cnt_ff == STEP_W'(QUO_W - 1));
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (status.op)
               OP_TICK: begin
                  if (status.tick_due) begin
                     cmd.tick_update = 1'b1;
                     state_in        = S_RPM_MUL;
                  end else begin
                     cmd.tick_count = 1'b1;
                     state_in       = S_RESP;
                  end
               end
               OP_TACH: begin
                  cmd.tach = 1'b1;
                  state_in = S_RESP;
               end
               OP_SET_SPEED: begin
                  cmd.set_speed = 1'b1;
                  state_in      = S_DUTY_MUL;
               end
               OP_NONE: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_RPM_MUL: begin
            cmd.rpm_mul = 1'b1;
            state_in    = S_RPM_CHK;
         end
         S_RPM_CHK: begin
            if (status.rpm_over) begin
               cmd.rpm_sat = 1'b1;
               state_in    = S_RESP;
            end else begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = S_DIV_RPM;
            end
         end
         S_DUTY_MUL: begin
            cmd.duty_mul = 1'b1;
            state_in     = S_DUTY_INIT;
         end
         S_DUTY_INIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV_DUTY;
         end
         S_DIV_RPM: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + STEP_W'(1);
            if (last_step) begin
               state_in = S_RPM_WB;
            end
         end
         S_DIV_DUTY: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + STEP_W'(1);
            if (last_step) begin
               state_in = S_DUTY_WB;
            end
         end
         S_RPM_WB: begin
            cmd.rpm_wb = 1'b1;
            state_in   = S_RESP;
         end
         S_DUTY_WB: begin
            cmd.duty_wb = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            // hold until the output register is free to take the beat
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `FPTC_ASSERT_NXT(a_accept_decodes, clock, reset, req_valid && !req_stall, state_ff == S_DECODE)
   `FPTC_ASSERT_NXT(a_div_advances, clock, reset, (state_ff == S_DIV_RPM) && !last_step, (state_ff == S_DIV_RPM) && (cnt_ff == STEP_W'($past(cnt_ff) + 1'b1)))
   `FPTC_ASSERT_NXT(a_resp_waits, clock, reset, (state_ff == S_RESP) && rsp_valid_ff && rsp_stall, state_ff == S_RESP)
   `FPTC_ASSERT_NXT(a_resp_loaded, clock, reset, (state_ff == S_RESP) && rsp_free, rsp_valid_ff && (state_ff == S_IDLE))

endmodule

// ===== test/tb_fan_pwm_tach_controller_core.sv =====
// Self-checking testbench for the fan PWM duty and tachometer rpm controller core.
`timescale 1ns / 1ps
module tb_fan_pwm_tach_controller_core;
   import fptc_pkg::*;

   localparam int STALL_LIMIT = 5000;

   typedef struct packed {
      logic [15:0] duty;
      logic        fan_on;
      logic [6:0]  speed_now;
      logic [15:0] rpm;
      logic [31:0] pulse_total;
   } fan_status_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = OP_NONE;
   logic [7:0]  req_speed_percent = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_duty;
   logic        rsp_fan_on;
   logic [6:0]  rsp_speed_now;
   logic [15:0] rsp_rpm;
   logic [31:0] rsp_pulse_total;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_PWM_RES;
   logic [15:0] csr_wdata = 16'd0;

   // Predicted controller state and register copies
   logic [4:0]  res_bits;
   logic [7:0]  ppr_copy;
   logic [15:0] ivl_copy;
   logic [31:0] pulse_cnt;
   logic [31:0] pulse_cnt_last;
   logic [15:0] ms_elapsed;
   logic [15:0] rpm_now;
   logic [6:0]  speed_now;
   logic        fan_on;
   logic [15:0] duty_now;

   fan_status_type status_q[$];
   fan_status_type want;
   int          err_count = 0;
   int          quiet_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   fan_pwm_tach_controller_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_speed_percent(req_speed_percent),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_duty         (rsp_duty),
      .rsp_fan_on       (rsp_fan_on),
      .rsp_speed_now    (rsp_speed_now),
      .rsp_rpm          (rsp_rpm),
      .rsp_pulse_total  (rsp_pulse_total),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   function automatic void reset_fan_model();
      res_bits       = 5'd8;
      ppr_copy       = 8'd2;
      ivl_copy       = 16'd1000;
      pulse_cnt      = '0;
      pulse_cnt_last = '0;
      ms_elapsed     = '0;
      rpm_now        = '0;
      speed_now      = '0;
      fan_on         = 1'b0;
      duty_now       = '0;
   endfunction

   // Apply one event to the predicted state and return the status it leaves.
   function automatic fan_status_type step_fan_model(op_type op, logic [7:0] pct);
      fan_status_type   st;
      int unsigned      ivl;
      int unsigned      bits;
      int unsigned      max_duty;
      int unsigned      capped;
      longint unsigned  pulses;
      longint unsigned  divisor;
      longint unsigned  quotient;
      case (op)
         OP_TICK: begin
            ivl = (ivl_copy == 0) ? 1 : ivl_copy;
            ms_elapsed = ms_elapsed + 16'd1;
            if (ms_elapsed >= ivl) begin
               pulses   = 32'(pulse_cnt - pulse_cnt_last);
               divisor  = ((ppr_copy == 0) ? 1 : ppr_copy) * longint'(ivl);
               quotient = (pulses * 64'd60000) / divisor;
               pulse_cnt_last = pulse_cnt;
               rpm_now    = (quotient > 65535) ? 16'hFFFF : quotient[15:0];
               ms_elapsed = '0;
            end
         end
         OP_TACH: begin
            pulse_cnt = pulse_cnt + 32'd1;
         end
         OP_SET_SPEED: begin
            bits     = (res_bits > 16) ? 16 : res_bits;
            max_duty = (1 << bits) - 1;
            capped   = (pct > 100) ? 100 : pct;
            speed_now = capped[6:0];
            if (capped > 0) begin
               duty_now = 16'((capped * max_duty) / 100);
               fan_on   = 1'b1;
            end else begin
               duty_now = '0;
               fan_on   = 1'b0;
            end
         end
         default: begin
         end
      endcase
      st.duty        = duty_now;
      st.fan_on      = fan_on;
      st.speed_now   = speed_now;
      st.rpm         = rpm_now;
      st.pulse_total = pulse_cnt;
      return st;
   endfunction

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_q.size() == 0) begin
            $error("unexpected result beat: duty=%0d rpm=%0d pulse_total=%0d",
                   rsp_duty, rsp_rpm, rsp_pulse_total);
            err_count++;
         end else begin
            want = status_q.pop_front();
            if (rsp_duty !== want.duty) begin
               $error("duty: expected %0d, got %0d", want.duty, rsp_duty);
               err_count++;
            end
            if (rsp_fan_on !== want.fan_on) begin
               $error("fan_on: expected %0d, got %0d", want.fan_on, rsp_fan_on);
               err_count++;
            end
            if (rsp_speed_now !== want.speed_now) begin
               $error("speed_now: expected %0d, got %0d", want.speed_now, rsp_speed_now);
               err_count++;
            end
            if (rsp_rpm !== want.rpm) begin
               $error("rpm: expected %0d, got %0d", want.rpm, rsp_rpm);
               err_count++;
            end
            if (rsp_pulse_total !== want.pulse_total) begin
               $error("pulse_total: expected %0d, got %0d", want.pulse_total,
                      rsp_pulse_total);
               err_count++;
            end
         end
      end
   end

   // Watchdog: give up when no beat moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_fan_pwm_tach_controller_core: done, errors");
            $finish;
         end
      end
   end

   task automatic send_event(op_type op, logic [7:0] pct);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_speed_percent <= pct;
      do @(posedge clock); while (req_stall);
      status_q.push_back(step_fan_model(op, pct));
   endtask

   // Drop valid and hold until every outstanding result has been taken
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (status_q.size() == 0);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] data);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PWM_RES: res_bits = data[4:0];
         CSR_PPR:     ppr_copy = data[7:0];
         CSR_IVL:     ivl_copy = data;
         default: begin
         end
      endcase
   endtask

   task automatic test_reset_state();
      send_event(OP_NONE, 8'hFF);
      send_event(OP_TICK, 8'h00);
      send_event(OP_TACH, 8'hAA);
   endtask

   task automatic test_speed_limits();
      send_event(OP_SET_SPEED, 8'd0);
      send_event(OP_SET_SPEED, 8'd1);
      send_event(OP_SET_SPEED, 8'd100);
      send_event(OP_SET_SPEED, 8'd101);
      send_event(OP_SET_SPEED, 8'd255);
      // duty holds until the next set-speed after a resolution change
      write_reg(CSR_PWM_RES, 16'd16);
      send_event(OP_NONE, 8'd0);
      send_event(OP_SET_SPEED, 8'd99);
      write_reg(CSR_PWM_RES, 16'd0);
      send_event(OP_SET_SPEED, 8'd50);
      write_reg(CSR_PWM_RES, 16'd31);
      send_event(OP_SET_SPEED, 8'd100);
      write_reg(CSR_PWM_RES, 16'd1);
      send_event(OP_SET_SPEED, 8'd100);
   endtask

   task automatic test_rpm_paths();
      write_reg(CSR_PPR, 16'd1);
      write_reg(CSR_IVL, 16'd1);
      send_event(OP_TACH, 8'd0);
      send_event(OP_TACH, 8'd0);
      send_event(OP_TICK, 8'd0);   // saturates
      send_event(OP_TICK, 8'd0);   // no pulses, rpm drops to zero
      write_reg(CSR_PPR, 16'd0);
      write_reg(CSR_IVL, 16'd0);
      send_event(OP_TACH, 8'd0);
      send_event(OP_TICK, 8'd0);
      write_reg(CSR_PPR, 16'd255);
      write_reg(CSR_IVL, 16'd65535);
      send_event(OP_TACH, 8'd0);
      send_event(OP_TICK, 8'd0);
      send_event(OP_TICK, 8'd0);
      send_event(OP_TICK, 8'd0);
      // interval now below the ticks already counted: update on the next tick
      write_reg(CSR_IVL, 16'd2);
      send_event(OP_TICK, 8'd0);
   endtask

   task automatic run_random_phase(int n_items, int s_idle, int r_stall, bit pause_midway);
      int          pick;
      logic [15:0] data;
      op_type      op;
      logic [7:0]  pct;
      pick = $urandom_range(9);
      data = 16'($urandom());
      if (pick == 0)      data[4:0] = 5'd0;
      else if (pick == 1) data[4:0] = 5'd16;
      else if (pick == 2) data[4:0] = 5'($urandom_range(31, 17));
      else                data[4:0] = 5'($urandom_range(16, 1));
      write_reg(CSR_PWM_RES, data);
      pick = $urandom_range(9);
      data = 16'($urandom());
      if (pick == 0)      data[7:0] = 8'd0;
      else if (pick == 1) data[7:0] = 8'd255;
      else if (pick < 5)  data[7:0] = 8'($urandom_range(255, 1));
      else                data[7:0] = 8'($urandom_range(8, 1));
      write_reg(CSR_PPR, data);
      pick = $urandom_range(9);
      if (pick == 0)      data = 16'd0;
      else if (pick == 1) data = 16'hFFFF;
      else if (pick == 2) data = 16'($urandom());
      else                data = 16'($urandom_range(16, 1));
      write_reg(CSR_IVL, data);
      send_idle_pct  = s_idle;
      recv_stall_pct = r_stall;
      for (int i = 0; i < n_items; i++) begin
         if (pause_midway && i == n_items / 2)
            wait_idle();
         pick = $urandom_range(99);
         if (pick < 45)      op = OP_TICK;
         else if (pick < 85) op = OP_TACH;
         else if (pick < 97) op = OP_SET_SPEED;
         else                op = OP_NONE;
         pct = $urandom_range(1) ? 8'($urandom_range(100)) : 8'($urandom_range(255));
         send_event(op, pct);
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      reset_fan_model();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_speed_limits();
      test_rpm_paths();
      run_random_phase(125, 0, 0, 1'b0);
      run_random_phase(125, 48, 0, 1'b0);
      run_random_phase(125, 0, 48, 1'b1);
      run_random_phase(125, 7, 7, 1'b0);
      run_random_phase(125, 0, 0, 1'b0);
      run_random_phase(125, 48, 0, 1'b0);
      run_random_phase(125, 0, 48, 1'b0);
      run_random_phase(125, 7, 7, 1'b0);
      wait_idle();
      repeat (50) @(posedge clock);
      if (err_count == 0 && status_q.size() == 0)
         $display("tb_fan_pwm_tach_controller_core: done, clean");
      else
         $display("tb_fan_pwm_tach_controller_core: done, errors");
      $finish;
   end

endmodule
